// ----- design/lfsc_pkg.sv -----
// Shared types and constants of the scan-line classifier.
package lfsc_pkg;

  localparam int SUM_W       = 15;
  localparam int WHITE_W     = 9;
  localparam int DRIVE_W     = 9;
  localparam int CFG_W       = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS   = SUM_W;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOLLOW_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_LEFT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_RIGHT = 3'd5;

  localparam logic [7:0]         RST_REGION_THR = 8'd95;
  localparam logic [7:0]         RST_FOLLOW_THR = 8'd127;
  localparam logic signed [8:0]  RST_BASE_SPEED = -9'sd90;
  localparam logic [9:0]         RST_STEER_GAIN = 10'd220;
  localparam logic signed [8:0]  RST_LOST_LEFT  = 9'sd70;
  localparam logic signed [8:0]  RST_LOST_RIGHT = 9'sd75;

  typedef enum logic [2:0] {
    MAN_INTERSECTION = 3'd0,
    MAN_TJUNCTION    = 3'd1,
    MAN_LEFT         = 3'd2,
    MAN_RIGHT        = 3'd3,
    MAN_FOLLOW       = 3'd4,
    MAN_LOST         = 3'd5
  } maneuver_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL,
    BK_FIN
  } back_state_e;

  typedef struct packed {
    maneuver_e                 maneuver;
    logic signed [SUM_W-1:0]   offset_sum;
    logic [WHITE_W-1:0]        white_count;
  } frame_sum_t;

  typedef struct packed {
    logic [7:0]        region_thr;
    logic [7:0]        follow_thr;
    logic signed [8:0] base_speed;
    logic [9:0]        steer_gain;
    logic signed [8:0] lost_left;
    logic signed [8:0] lost_right;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ----- design/line_follow_scanline_classifier.sv -----
// Top level of the scan-line line-follower classifier.
// Pixels enter on the in_* channel (column, row, luma, frame_last) and are
// taken one per cycle; in_stall_o rises only while both frame summaries in
// the internal queue are still waiting for the back end.
// On the pixel with frame_last set, the frame's counts are classified and
// queued; one result leaves on the out_* channel per frame.
// A result for intersection, T-junction, left, right and lost goes from the
// queue through the idle and finish states to the output register; a follow
// result also passes the 15-step serial divide of the centroid sum and the
// multiply and drive stage. Waiting frame summaries back up in the queue.
// The result sits in an output register; while out_stall_i is high it holds
// and the back end waits, and the front takes pixels until the queue fills.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 region threshold, 1 follow threshold, 2 base speed, 3 steer gain Q8,
// 4 lost left speed, 5 lost right speed); other indices are ignored.
// Write only while idle. Reset clears all counts, empties the queue and
// loads the default register values.
module line_follow_scanline_classifier #(
  parameter int LINE_WIDTH     = 320,
  parameter int SCAN_ROW       = 120,
  parameter int FORWARD_COLUMN = 140
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lfsc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lfsc_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [8:0]                          column_i,
  input  logic [7:0]                          row_i,
  input  logic [7:0]                          luma_i,
  input  logic                                frame_last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [2:0]                          out_maneuver_o,
  output logic signed [8:0]                   out_mean_error_o,
  output logic signed [8:0]                   out_left_drive_o,
  output logic signed [8:0]                   out_right_drive_o
);

  lfsc_pkg::cfg_t          cfg_q;
  lfsc_pkg::queue_status_t q_status;
  lfsc_pkg::frame_sum_t    push_data, head;
  logic push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.region_thr <= lfsc_pkg::RST_REGION_THR;
      cfg_q.follow_thr <= lfsc_pkg::RST_FOLLOW_THR;
      cfg_q.base_speed <= lfsc_pkg::RST_BASE_SPEED;
      cfg_q.steer_gain <= lfsc_pkg::RST_STEER_GAIN;
      cfg_q.lost_left  <= lfsc_pkg::RST_LOST_LEFT;
      cfg_q.lost_right <= lfsc_pkg::RST_LOST_RIGHT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lfsc_pkg::REG_REGION_THR: cfg_q.region_thr <= cfg_data_i[7:0];
        lfsc_pkg::REG_FOLLOW_THR: cfg_q.follow_thr <= cfg_data_i[7:0];
        lfsc_pkg::REG_BASE_SPEED: cfg_q.base_speed <= cfg_data_i[8:0];
        lfsc_pkg::REG_STEER_GAIN: cfg_q.steer_gain <= cfg_data_i;
        lfsc_pkg::REG_LOST_LEFT:  cfg_q.lost_left  <= cfg_data_i[8:0];
        lfsc_pkg::REG_LOST_RIGHT: cfg_q.lost_right <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  lfsc_front #(
    .LINE_WIDTH     (LINE_WIDTH),
    .SCAN_ROW       (SCAN_ROW),
    .FORWARD_COLUMN (FORWARD_COLUMN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .column_i     (column_i),
    .row_i        (row_i),
    .luma_i       (luma_i),
    .frame_last_i (frame_last_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .entry_o      (push_data)
  );

  lfsc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  lfsc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .head_i            (head),
    .q_status_i        (q_status),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_maneuver_o    (out_maneuver_o),
    .out_mean_error_o  (out_mean_error_o),
    .out_left_drive_o  (out_left_drive_o),
    .out_right_drive_o (out_right_drive_o)
  );

  a_man_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_maneuver_o <= lfsc_pkg::MAN_LOST)
    else $error("maneuver code out of range");

  a_idle_drives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_maneuver_o != lfsc_pkg::MAN_FOLLOW
     && out_maneuver_o != lfsc_pkg::MAN_LOST)
    |-> (out_left_drive_o == '0 && out_right_drive_o == '0 && out_mean_error_o == '0))
    else $error("drives not zero outside follow and lost");

  a_drive_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_left_drive_o != 9'h100 && out_right_drive_o != 9'h100))
    else $error("drive escaped saturation");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

endmodule

// ----- design/lfsc_front.sv -----
// Front end: per-pixel window counts, centroid sums and frame classification.
module lfsc_front #(
  parameter int LINE_WIDTH     = 320,
  parameter int SCAN_ROW       = 120,
  parameter int FORWARD_COLUMN = 140
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lfsc_pkg::cfg_t           cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [8:0]               column_i,
  input  logic [7:0]               row_i,
  input  logic [7:0]               luma_i,
  input  logic                     frame_last_i,
  input  lfsc_pkg::queue_status_t  q_status_i,
  output logic                     push_o,
  output lfsc_pkg::frame_sum_t     entry_o
);

  localparam int Half     = LINE_WIDTH / 2;
  localparam int CenterLo = Half - 5;
  localparam int CenterHi = Half + 5;
  localparam int RightLo  = LINE_WIDTH - 20;
  localparam int LeftEnd  = 20;
  localparam int FwdRows  = 30;

  logic [4:0] left_q, left_d;
  logic [3:0] center_q, center_d;
  logic [4:0] right_q, right_d;
  logic [4:0] fwd_q, fwd_d;
  logic signed [lfsc_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [lfsc_pkg::WHITE_W-1:0] white_q, white_d;

  logic accept;
  logic in_line, on_row, reg_white, fol_white;
  logic signed [9:0]  diff;
  logic signed [15:0] sum_wide;
  lfsc_pkg::maneuver_e man;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = accept && frame_last_i;

  always_comb begin
    in_line   = int'(column_i) < LINE_WIDTH;
    on_row    = in_line && (int'(row_i) == SCAN_ROW);
    reg_white = luma_i > cfg_i.region_thr;
    fol_white = luma_i > cfg_i.follow_thr;
    diff      = 10'(int'(column_i) - Half);
    sum_wide  = {sum_q[lfsc_pkg::SUM_W-1], sum_q} + {{6{diff[9]}}, diff};

    left_d   = left_q;
    center_d = center_q;
    right_d  = right_q;
    fwd_d    = fwd_q;
    sum_d    = sum_q;
    white_d  = white_q;

    if (on_row && reg_white) begin
      if (int'(column_i) < LeftEnd && left_q != '1) left_d = left_q + 5'd1;
      if (int'(column_i) >= CenterLo && int'(column_i) < CenterHi && center_q != '1)
        center_d = center_q + 4'd1;
      if (int'(column_i) >= RightLo && right_q != '1) right_d = right_q + 5'd1;
    end
    if (on_row && fol_white) begin
      if (sum_wide[15] != sum_wide[14]) begin
        sum_d = sum_wide[15] ? {1'b1, {(lfsc_pkg::SUM_W-1){1'b0}}}
                             : {1'b0, {(lfsc_pkg::SUM_W-1){1'b1}}};
      end else begin
        sum_d = sum_wide[14:0];
      end
      if (white_q != '1) white_d = white_q + 9'd1;
    end
    if (in_line && int'(column_i) == FORWARD_COLUMN && int'(row_i) < FwdRows && reg_white
        && fwd_q != '1)
      fwd_d = fwd_q + 5'd1;

    if (center_d > 4'd7 && left_d > 5'd10 && right_d > 5'd10 && fwd_d >= 5'd30)
      man = lfsc_pkg::MAN_INTERSECTION;
    else if (center_d > 4'd7 && left_d > 5'd10 && right_d > 5'd10)
      man = lfsc_pkg::MAN_TJUNCTION;
    else if (center_d > 4'd7 && left_d > 5'd7 && right_d == 5'd0 && fwd_d < 5'd20)
      man = lfsc_pkg::MAN_LEFT;
    else if (center_d > 4'd7 && right_d > 5'd10 && left_d == 5'd0 && fwd_d < 5'd20)
      man = lfsc_pkg::MAN_RIGHT;
    else if (white_d != '0)
      man = lfsc_pkg::MAN_FOLLOW;
    else
      man = lfsc_pkg::MAN_LOST;

    entry_o.maneuver    = man;
    entry_o.offset_sum  = sum_d;
    entry_o.white_count = white_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      center_q <= '0;
      right_q  <= '0;
      fwd_q    <= '0;
      sum_q    <= '0;
      white_q  <= '0;
    end else if (accept) begin
      if (frame_last_i) begin
        left_q   <= '0;
        center_q <= '0;
        right_q  <= '0;
        fwd_q    <= '0;
        sum_q    <= '0;
        white_q  <= '0;
      end else begin
        left_q   <= left_d;
        center_q <= center_d;
        right_q  <= right_d;
        fwd_q    <= fwd_d;
        sum_q    <= sum_d;
        white_q  <= white_d;
      end
    end
  end

endmodule

// ----- design/lfsc_queue.sv -----
// Short queue of frame summaries between front and back.
module lfsc_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  lfsc_pkg::frame_sum_t     push_data_i,
  input  logic                     pop_i,
  output lfsc_pkg::frame_sum_t     head_o,
  output lfsc_pkg::queue_status_t  status_o
);

  localparam int PtrW = $clog2(lfsc_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(lfsc_pkg::QUEUE_DEPTH + 1);

  lfsc_pkg::frame_sum_t mem_q [lfsc_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign status_o.full  = cnt_q == CntW'(lfsc_pkg::QUEUE_DEPTH);
  assign status_o.empty = cnt_q == '0;
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (int'(wr_q) == lfsc_pkg::QUEUE_DEPTH - 1) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (int'(rd_q) == lfsc_pkg::QUEUE_DEPTH - 1) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

// ----- design/lfsc_back.sv -----
// Back end: centroid divide, steering multiply, drive saturation and result register.
module lfsc_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lfsc_pkg::cfg_t                       cfg_i,
  input  lfsc_pkg::frame_sum_t                 head_i,
  input  lfsc_pkg::queue_status_t              q_status_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [2:0]                           out_maneuver_o,
  output logic signed [8:0]                    out_mean_error_o,
  output logic signed [lfsc_pkg::DRIVE_W-1:0]  out_left_drive_o,
  output logic signed [lfsc_pkg::DRIVE_W-1:0]  out_right_drive_o
);

  localparam int SW = lfsc_pkg::SUM_W;
  localparam int CntW = $clog2(lfsc_pkg::DIV_STEPS);

  lfsc_pkg::back_state_e state_q, state_d;

  lfsc_pkg::maneuver_e man_q;
  logic                neg_q;
  logic [SW-1:0]       quo_q;
  logic [8:0]          div_q;
  logic [9:0]          rem_q;
  logic [CntW-1:0]     cnt_q;
  logic signed [8:0]   err_q;
  logic signed [19:0]  prod_q;

  logic out_valid_q;
  logic [2:0] man_out_q;
  logic signed [8:0] err_out_q, left_out_q, right_out_q;

  logic out_free, load_out, div_last;
  logic [10:0] shifted;
  logic [10:0] trial;
  logic        qbit;
  logic signed [8:0]  err_c;
  logic signed [20:0] base_ext, vl, vr;
  logic signed [8:0]  left_c, right_c;

  function automatic logic signed [8:0] sat_drive(input logic signed [20:0] v);
    logic signed [20:0] t;
    logic signed [12:0] q;
    t = v + (v[20] ? 21'sd255 : 21'sd0);
    q = 13'(t >>> 8);
    if (q > 13'sd255) return 9'sd255;
    else if (q < -13'sd255) return -9'sd255;
    else return q[8:0];
  endfunction

  function automatic logic signed [8:0] sat_speed(input logic signed [8:0] v);
    return (v == 9'h100) ? -9'sd255 : v;
  endfunction

  assign out_free = !out_valid_q || !out_stall_i;
  assign div_last = cnt_q == CntW'(lfsc_pkg::DIV_STEPS - 1);

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      lfsc_pkg::BK_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o = 1'b1;
          state_d = (head_i.maneuver == lfsc_pkg::MAN_FOLLOW) ? lfsc_pkg::BK_DIV
                                                              : lfsc_pkg::BK_FIN;
        end
      end
      lfsc_pkg::BK_DIV: begin
        if (div_last) state_d = lfsc_pkg::BK_MUL;
      end
      lfsc_pkg::BK_MUL: state_d = lfsc_pkg::BK_FIN;
      lfsc_pkg::BK_FIN: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = lfsc_pkg::BK_IDLE;
        end
      end
      default: state_d = lfsc_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= lfsc_pkg::BK_IDLE;
    else         state_q <= state_d;
  end

  // restoring divide, one quotient bit per cycle
  always_comb begin
    shifted = {rem_q, quo_q[SW-1]};
    trial   = shifted - {2'b0, div_q};
    qbit    = shifted >= {2'b0, div_q};
  end

  always_comb begin
    if (neg_q) err_c = (quo_q > SW'(256)) ? -9'sd256 : 9'(9'd0 - quo_q[8:0]);
    else       err_c = (quo_q > SW'(255)) ? 9'sd255 : quo_q[8:0];
  end

  always_comb begin
    base_ext = {{4{cfg_i.base_speed[8]}}, cfg_i.base_speed, 8'b0};
    vl       = base_ext + {prod_q[19], prod_q};
    vr       = base_ext - {prod_q[19], prod_q};
    left_c   = sat_drive(vl);
    right_c  = sat_drive(vr);
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      lfsc_pkg::BK_IDLE: begin
        man_q <= head_i.maneuver;
        neg_q <= head_i.offset_sum[SW-1];
        quo_q <= head_i.offset_sum[SW-1] ? SW'(-head_i.offset_sum) : head_i.offset_sum;
        div_q <= head_i.white_count;
        rem_q <= '0;
        cnt_q <= '0;
      end
      lfsc_pkg::BK_DIV: begin
        rem_q <= qbit ? trial[9:0] : shifted[9:0];
        quo_q <= {quo_q[SW-2:0], qbit};
        cnt_q <= cnt_q + CntW'(1);
      end
      lfsc_pkg::BK_MUL: begin
        err_q  <= err_c;
        prod_q <= $signed({1'b0, cfg_i.steer_gain}) * err_c;
      end
      default: ;
    endcase
    if (load_out) begin
      man_out_q <= man_q;
      case (man_q)
        lfsc_pkg::MAN_FOLLOW: begin
          err_out_q   <= err_q;
          left_out_q  <= left_c;
          right_out_q <= right_c;
        end
        lfsc_pkg::MAN_LOST: begin
          err_out_q   <= '0;
          left_out_q  <= sat_speed(cfg_i.lost_left);
          right_out_q <= sat_speed(cfg_i.lost_right);
        end
        default: begin
          err_out_q   <= '0;
          left_out_q  <= '0;
          right_out_q <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       out_valid_q <= 1'b0;
    else if (load_out) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  assign out_valid_o       = out_valid_q;
  assign out_maneuver_o    = man_out_q;
  assign out_mean_error_o  = err_out_q;
  assign out_left_drive_o  = left_out_q;
  assign out_right_drive_o = right_out_q;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the scan-line line-follower classifier.
module tb_top;

  localparam int LINE_W       = 320;
  localparam int HALF         = LINE_W / 2;
  localparam int SCAN_ROW     = 120;
  localparam int FWD_COL      = 140;
  localparam int DRAIN_CYCLES = 24;
  localparam int QUIET_LIMIT  = 4000;
  localparam logic [lfsc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd6;

  typedef struct packed {
    logic [8:0] col;
    logic [7:0] row;
    logic [7:0] luma;
    logic       last;
  } pix_t;

  typedef struct packed {
    lfsc_pkg::maneuver_e man;
    logic signed [8:0]   err;
    logic signed [8:0]   ld;
    logic signed [8:0]   rd;
  } steer_t;

  typedef enum int {
    FR_CROSS, FR_TEE, FR_LEFT, FR_RIGHT, FR_FOLLOW, FR_LOST, FR_MIXED, FR_SHORT
  } frame_kind_e;

  logic                           clk_i;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic [lfsc_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [lfsc_pkg::CFG_W-1:0]     cfg_data_i  = '0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  logic [8:0]                     column_i    = '0;
  logic [7:0]                     row_i       = '0;
  logic [7:0]                     luma_i      = '0;
  logic                           frame_last_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [2:0]                     out_maneuver_o;
  logic signed [8:0]              out_mean_error_o;
  logic signed [8:0]              out_left_drive_o;
  logic signed [8:0]              out_right_drive_o;

  // register shadow
  logic [7:0]        thr_region = lfsc_pkg::RST_REGION_THR;
  logic [7:0]        thr_follow = lfsc_pkg::RST_FOLLOW_THR;
  logic signed [8:0] spd_base   = lfsc_pkg::RST_BASE_SPEED;
  logic [9:0]        gain_q8    = lfsc_pkg::RST_STEER_GAIN;
  logic signed [8:0] spd_lost_l = lfsc_pkg::RST_LOST_LEFT;
  logic signed [8:0] spd_lost_r = lfsc_pkg::RST_LOST_RIGHT;

  // frame accumulators
  int px_left, px_center, px_right, px_fwd, px_sum, px_white;

  pix_t   pixel_q[$];
  steer_t due_steer_q[$];

  bit pix_taken;
  int send_gap, stall_left, hold_left;
  int send_idle_pct, recv_idle_pct;
  int n_queued, n_pixels, n_results, n_fail, n_settings, quiet;
  int man_seen[6];

  line_follow_scanline_classifier DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .column_i          (column_i),
    .row_i             (row_i),
    .luma_i            (luma_i),
    .frame_last_i      (frame_last_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_maneuver_o    (out_maneuver_o),
    .out_mean_error_o  (out_mean_error_o),
    .out_left_drive_o  (out_left_drive_o),
    .out_right_drive_o (out_right_drive_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int sat_up(int v, int top);
    return (v < top) ? v + 1 : top;
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int pick_gap(int idle_pct);
    int r;
    if ($urandom_range(99, 0) >= idle_pct) return 0;
    r = $urandom_range(99, 0);
    if (r < 70) return $urandom_range(2, 1);
    if (r < 95) return $urandom_range(8, 3);
    return $urandom_range(60, 20);
  endfunction

  function automatic int shade(int pb, logic [7:0] thr);
    if ($urandom_range(99, 0) < pb && thr != 8'd255)
      return $urandom_range(255, int'(thr) + 1);
    return $urandom_range(int'(thr), 0);
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    n_fail++;
    if (n_fail <= 40)
      $display("mismatch at result %0d, %s: got %0d, want %0d", n_results, what, got, want);
  endtask

  task automatic track_pixel(input logic [8:0] col, input logic [7:0] row,
                             input logic [7:0] luma, input logic last);
    steer_t res;
    int     err, delta;
    logic   region_white;
    res = '{man: lfsc_pkg::MAN_LOST, err: '0, ld: '0, rd: '0};
    if (col < LINE_W) begin
      region_white = luma > thr_region;
      if (row == SCAN_ROW) begin
        if (region_white) begin
          if (col < 20) px_left = sat_up(px_left, 31);
          if (col >= HALF - 5 && col < HALF + 5) px_center = sat_up(px_center, 15);
          if (col >= LINE_W - 20) px_right = sat_up(px_right, 31);
        end
        if (luma > thr_follow) begin
          px_sum   = clip(px_sum + int'(col) - HALF, -16384, 16383);
          px_white = sat_up(px_white, 511);
        end
      end
      if (col == FWD_COL && row < 30 && region_white) px_fwd = sat_up(px_fwd, 31);
    end
    if (last) begin
      if (px_center > 7 && px_left > 10 && px_right > 10 && px_fwd >= 30)
        res.man = lfsc_pkg::MAN_INTERSECTION;
      else if (px_center > 7 && px_left > 10 && px_right > 10)
        res.man = lfsc_pkg::MAN_TJUNCTION;
      else if (px_center > 7 && px_left > 7 && px_right == 0 && px_fwd < 20)
        res.man = lfsc_pkg::MAN_LEFT;
      else if (px_center > 7 && px_right > 10 && px_left == 0 && px_fwd < 20)
        res.man = lfsc_pkg::MAN_RIGHT;
      else if (px_white > 0)
        res.man = lfsc_pkg::MAN_FOLLOW;
      if (res.man == lfsc_pkg::MAN_FOLLOW) begin
        err    = clip(px_sum / px_white, -256, 255);
        delta  = int'(gain_q8) * err;
        res.err = 9'(err);
        res.ld  = 9'(clip((int'(spd_base) * 256 + delta) / 256, -255, 255));
        res.rd  = 9'(clip((int'(spd_base) * 256 - delta) / 256, -255, 255));
      end else if (res.man == lfsc_pkg::MAN_LOST) begin
        res.ld = 9'(clip(int'(spd_lost_l), -255, 255));
        res.rd = 9'(clip(int'(spd_lost_r), -255, 255));
      end
      due_steer_q.push_back(res);
      px_left = 0; px_center = 0; px_right = 0; px_fwd = 0; px_sum = 0; px_white = 0;
    end
  endtask

  task automatic push_px(input int col, input int row, input int luma, input bit last);
    pix_t px;
    px.col  = 9'(col);
    px.row  = 8'(row);
    px.luma = 8'(luma);
    px.last = last;
    pixel_q.push_back(px);
    n_queued++;
  endtask

  task automatic push_noise(input bit last);
    int row;
    row = $urandom_range(255, 0);
    if (row == SCAN_ROW) row++;
    push_px($urandom_range(511, 0), row, $urandom_range(255, 0), last);
  endtask

  task automatic queue_frame(input frame_kind_e kind);
    int nl, nc, nr, nf, nline, nnoise, pb;
    nl = 0; nc = 0; nr = 0; nf = 0; nline = 0; pb = 100;
    nnoise = $urandom_range(4, 0);
    case (kind)
      FR_CROSS, FR_TEE: begin
        nl = $urandom_range(22, 11);
        nc = $urandom_range(18, 8);
        nr = $urandom_range(22, 11);
        nf = (kind == FR_CROSS) ? $urandom_range(34, 30) : $urandom_range(29, 0);
      end
      FR_LEFT: begin
        nl = $urandom_range(14, 8);
        nc = $urandom_range(12, 8);
        nf = $urandom_range(19, 0);
      end
      FR_RIGHT: begin
        nr = $urandom_range(16, 11);
        nc = $urandom_range(12, 8);
        nf = $urandom_range(19, 0);
      end
      FR_FOLLOW: begin
        nl = $urandom_range(6, 0);
        nc = $urandom_range(7, 0);
        nr = $urandom_range(6, 0);
        nf = $urandom_range(12, 0);
        nline = $urandom_range(24, 1);
        pb = 70;
      end
      FR_MIXED: begin
        nl = $urandom_range(13, 5);
        nc = $urandom_range(10, 5);
        nr = $urandom_range(13, 0);
        nf = $urandom_range(32, 15);
        nline = $urandom_range(6, 0);
        pb = 80;
      end
      FR_SHORT: begin
        nnoise = $urandom_range(2, 0);
        nline = $urandom_range(1, 0);
      end
      default: nline = $urandom_range(6, 0);
    endcase
    repeat (nl) push_px($urandom_range(19, 0), SCAN_ROW, shade(pb, thr_region), 0);
    repeat (nc) push_px($urandom_range(HALF + 4, HALF - 5), SCAN_ROW, shade(pb, thr_region), 0);
    repeat (nr)
      push_px($urandom_range(LINE_W - 1, LINE_W - 20), SCAN_ROW, shade(pb, thr_region), 0);
    repeat (nf) push_px(FWD_COL, $urandom_range(29, 0), shade(pb, thr_region), 0);
    // lost frames keep the scan row at or below the follow threshold
    repeat (nline)
      push_px($urandom_range(LINE_W - 1, 0), SCAN_ROW,
              (kind == FR_LOST) ? $urandom_range(int'(thr_follow), 0) : $urandom_range(255, 0), 0);
    repeat (nnoise) push_noise(0);
    push_noise(1);
  endtask

  task automatic run_phase(input int target);
    int start;
    int r;
    start = n_queued;
    while (n_queued - start < target) begin
      r = $urandom_range(99, 0);
      if (r < 12)      queue_frame(FR_CROSS);
      else if (r < 24) queue_frame(FR_TEE);
      else if (r < 38) queue_frame(FR_LEFT);
      else if (r < 52) queue_frame(FR_RIGHT);
      else if (r < 74) queue_frame(FR_FOLLOW);
      else if (r < 86) queue_frame(FR_LOST);
      else             queue_frame(FR_MIXED);
    end
  endtask

  task automatic settle();
    while (pixel_q.size() != 0 || in_valid_i || due_steer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [lfsc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lfsc_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      lfsc_pkg::REG_REGION_THR: thr_region = data[7:0];
      lfsc_pkg::REG_FOLLOW_THR: thr_follow = data[7:0];
      lfsc_pkg::REG_BASE_SPEED: spd_base   = data[8:0];
      lfsc_pkg::REG_STEER_GAIN: gain_q8    = data[9:0];
      lfsc_pkg::REG_LOST_LEFT:  spd_lost_l = data[8:0];
      lfsc_pkg::REG_LOST_RIGHT: spd_lost_r = data[8:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sender
  always @(negedge clk_i) begin : drv
    pix_t px;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !pix_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        px = pixel_q.pop_front();
        column_i     <= px.col;
        row_i        <= px.row;
        luma_i       <= px.luma;
        frame_last_i <= px.last;
        in_valid_i   <= 1'b1;
        send_gap = pick_gap(send_idle_pct);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    pix_taken = 1'b0;
  end

  // receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = pick_gap(recv_idle_pct);
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin : mon
    steer_t want;
    if (out_valid_o && !out_stall_i) begin
      n_results++;
      if (out_maneuver_o < 6) man_seen[out_maneuver_o]++;
      if (due_steer_q.size() == 0) begin
        flag_mismatch("result with nothing pending", out_maneuver_o, -1);
      end else begin
        want = due_steer_q.pop_front();
        if (out_maneuver_o !== want.man)
          flag_mismatch("maneuver", out_maneuver_o, want.man);
        if (out_mean_error_o !== want.err)
          flag_mismatch("mean_error", out_mean_error_o, want.err);
        if (out_left_drive_o !== want.ld)
          flag_mismatch("left_drive", out_left_drive_o, want.ld);
        if (out_right_drive_o !== want.rd)
          flag_mismatch("right_drive", out_right_drive_o, want.rd);
      end
    end
    if (in_valid_i && !in_stall_o) begin
      n_pixels++;
      pix_taken = 1'b1;
      track_pixel(column_i, row_i, luma_i, frame_last_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results pending",
               quiet, due_steer_q.size());
      $display("line_follow_scanline_classifier verification failed");
      $finish;
    end
  end

  initial begin : stim
    int v;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    n_settings = 1;
    send_idle_pct = 30;
    recv_idle_pct = 30;

    // single-pixel frames at the field extremes, then truncation of the mean
    push_px(0, 0, 0, 1);
    push_px(319, SCAN_ROW, 255, 1);
    push_px(0, SCAN_ROW, 255, 1);
    push_px(511, 255, 255, 1);
    push_px(320, SCAN_ROW, 255, 1);
    push_px(160, SCAN_ROW, 128, 1);
    push_px(160, SCAN_ROW, 127, 1);
    push_px(FWD_COL, 29, 96, 1);
    push_px(FWD_COL, 30, 255, 1);
    push_px(FWD_COL, SCAN_ROW, 96, 1);
    push_px(256, 240, 170, 0);
    push_px(157, SCAN_ROW, 200, 0);
    push_px(158, SCAN_ROW, 200, 1);
    push_px(155, SCAN_ROW, 200, 0);
    push_px(164, SCAN_ROW, 200, 1);

    for (int k = 0; k <= int'(FR_MIXED); k++) queue_frame(frame_kind_e'(k));
    // counter and sum saturation
    repeat (514) push_px(319, SCAN_ROW, 255, 0);
    push_px(319, SCAN_ROW, 255, 1);
    repeat (109) push_px(0, SCAN_ROW, 255, 0);
    push_px(0, SCAN_ROW, 255, 1);
    run_phase(120);
    settle();

    write_reg(lfsc_pkg::REG_REGION_THR, 10'd0);
    write_reg(lfsc_pkg::REG_FOLLOW_THR, 10'd0);
    write_reg(lfsc_pkg::REG_BASE_SPEED, 10'h0FF);
    write_reg(lfsc_pkg::REG_STEER_GAIN, 10'd1023);
    write_reg(lfsc_pkg::REG_LOST_LEFT, 10'h0FF);
    write_reg(lfsc_pkg::REG_LOST_RIGHT, 10'h101);
    n_settings++;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(90);
    settle();

    write_reg(lfsc_pkg::REG_REGION_THR, 10'h3FF);
    write_reg(lfsc_pkg::REG_FOLLOW_THR, 10'h0FF);
    write_reg(lfsc_pkg::REG_BASE_SPEED, 10'h101);
    write_reg(lfsc_pkg::REG_STEER_GAIN, 10'd0);
    write_reg(lfsc_pkg::REG_LOST_LEFT, 10'h100);
    write_reg(lfsc_pkg::REG_LOST_RIGHT, 10'h200);
    write_reg(REG_UNUSED, 10'h155);
    n_settings++;
    send_idle_pct = 50;
    recv_idle_pct = 10;
    run_phase(80);
    settle();

    repeat (3) begin
      write_reg(lfsc_pkg::REG_REGION_THR, 10'($urandom));
      write_reg(lfsc_pkg::REG_FOLLOW_THR, 10'($urandom));
      v = $urandom_range(510, 0) - 255;
      write_reg(lfsc_pkg::REG_BASE_SPEED, {1'($urandom), 9'(v)});
      write_reg(lfsc_pkg::REG_STEER_GAIN, 10'($urandom));
      v = $urandom_range(510, 0) - 255;
      write_reg(lfsc_pkg::REG_LOST_LEFT, {1'($urandom), 9'(v)});
      v = $urandom_range(510, 0) - 255;
      write_reg(lfsc_pkg::REG_LOST_RIGHT, {1'($urandom), 9'(v)});
      n_settings++;
      send_idle_pct = $urandom_range(50, 0);
      recv_idle_pct = $urandom_range(50, 0);
      run_phase(55);
      settle();
    end

    // output held off while short frames keep coming: frame queue fills up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 400;
    repeat (40) queue_frame(FR_SHORT);
    settle();

    $display("run: %0d pixels, %0d frame results, %0d register settings, incl. saturation",
             n_pixels, n_results, n_settings);
    $display("maneuvers: intersection %0d, T %0d, left %0d, right %0d, follow %0d, lost %0d",
             man_seen[0], man_seen[1], man_seen[2], man_seen[3], man_seen[4], man_seen[5]);
    if (n_fail == 0) begin
      $display("line_follow_scanline_classifier verification clean");
    end else begin
      $display("line_follow_scanline_classifier verification failed");
    end
    $finish;
  end

endmodule
